[rtl/fmcc_pkg.sv]
// Shared types, constants and the CRC-16 byte update for the frame checker.
package fmcc_pkg;

	localparam logic [15:0] CRC_INIT        = 16'hFFFF;
	localparam logic [15:0] CRC_POLY        = 16'hA001;
	localparam logic [7:0]  START_BYTE_RST  = 8'h7E;
	localparam logic [2:0]  COUNT_MAX       = 3'd4;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TOO_SHORT = 2'd1,
		ST_BAD_START = 2'd2,
		ST_BAD_CRC   = 2'd3
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  message_id;
		logic [15:0] computed_crc;
	} result_t;

	// Fold one byte into a reflected CRC-16, one bit per step.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[rtl/fmcc_stream_if.sv]
// Valid/ready channel interfaces for received bytes and frame results.
interface fmcc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fmcc_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  message_id;
	logic [15:0] computed_crc;

	modport source (output valid, output status, output message_id, output computed_crc,
		input ready);
	modport sink   (input valid, input status, input message_id, input computed_crc,
		output ready);
endinterface

[rtl/fmcc_frame.sv]
// Per-frame tracking: held trailer bytes, running CRC, header check and result build.
module fmcc_frame (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	input  logic [7:0]          start_byte,
	output fmcc_pkg::result_t   result
);

	logic [15:0] crc_q;
	logic [7:0]  older_q;
	logic [7:0]  newer_q;
	logic [2:0]  count_q;
	logic        header_q;
	logic [7:0]  id_q;

	logic [15:0] crc_d;
	logic        header_d;
	logic [7:0]  id_d;
	logic [15:0] trailer;

	// Work out the state this item leaves behind
	always_comb begin
		header_d = (count_q == 3'd0) ? (data_byte == start_byte) : header_q;
		id_d     = (count_q == 3'd1) ? data_byte : id_q;
		crc_d    = (count_q >= 3'd2) ? fmcc_pkg::crc_feed(crc_q, older_q) : crc_q;
		trailer  = {data_byte, newer_q};
	end

	// Build the result for a frame that ends on this item
	always_comb begin
		result.message_id   = (count_q >= 3'd1) ? id_d : 8'h00;
		result.computed_crc = crc_d;
		if (count_q < 3'd3) begin
			result.status = fmcc_pkg::ST_TOO_SHORT;
		end else if (!header_d) begin
			result.status = fmcc_pkg::ST_BAD_START;
		end else if (trailer != crc_d) begin
			result.status = fmcc_pkg::ST_BAD_CRC;
		end else begin
			result.status = fmcc_pkg::ST_OK;
		end
	end

	// Advance frame state; clear it after the final item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= fmcc_pkg::CRC_INIT;
			older_q  <= 8'h00;
			newer_q  <= 8'h00;
			count_q  <= 3'd0;
			header_q <= 1'b0;
			id_q     <= 8'h00;
		end else if (accept) begin
			if (last_byte) begin
				crc_q    <= fmcc_pkg::CRC_INIT;
				older_q  <= 8'h00;
				newer_q  <= 8'h00;
				count_q  <= 3'd0;
				header_q <= 1'b0;
				id_q     <= 8'h00;
			end else begin
				crc_q    <= crc_d;
				older_q  <= newer_q;
				newer_q  <= data_byte;
				header_q <= header_d;
				id_q     <= id_d;
				if (count_q < fmcc_pkg::COUNT_MAX) begin
					count_q <= count_q + 3'd1;
				end
			end
		end
	end

endmodule

[rtl/framed_message_crc_checker.sv]
// Top level of the framed message checker with CRC-16 trailer verification.
//
//   channel    dir   handshake        payload
//   rx_byte    in    valid / ready    data_byte[7:0], last_byte
//   result     out   valid / ready    status[1:0], message_id[7:0], computed_crc[15:0]
//   wr_*       in    wr_en            wr_data[7:0] -> start byte register
//
// One byte is taken every cycle unless rx_byte is stalled; the byte-wise CRC update sits
// between frame state and result registers; a result is valid the cycle after its last byte.
// A result waits in its register; a new byte is still taken while the
// result is being delivered, and only a held result with result.ready low stalls rx_byte.
// Reset clears frame state, the result register and sets the start byte to 0x7E.
module framed_message_crc_checker (
	input  logic              clk,
	input  logic              arst_n,
	fmcc_byte_if.sink         rx_byte,
	fmcc_result_if.source     result,
	input  logic              wr_en,
	input  logic [7:0]        wr_data
);

	logic [7:0]         start_byte_q;
	logic               out_valid_q;
	fmcc_pkg::result_t  result_q;
	fmcc_pkg::result_t  frame_result;
	logic               accept;

	assign rx_byte.ready = !out_valid_q || result.ready;
	assign accept        = rx_byte.valid && rx_byte.ready;

	// Hold the expected start byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= fmcc_pkg::START_BYTE_RST;
		end else if (wr_en) begin
			start_byte_q <= wr_data;
		end
	end

	fmcc_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (rx_byte.data_byte),
		.last_byte  (rx_byte.last_byte),
		.start_byte (start_byte_q),
		.result     (frame_result)
	);

	// Load a result on the final item; drop the valid once it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && rx_byte.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Capture the result payload on the final item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_q <= '0;
		end else if (accept && rx_byte.last_byte) begin
			result_q <= frame_result;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.status       = result_q.status;
	assign result.message_id   = result_q.message_id;
	assign result.computed_crc = result_q.computed_crc;

endmodule

[rtl/fmcc_checker.sv]
// Port-level checks for the frame checker, bound to its top level.
module fmcc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rx_valid,
	input logic        rx_ready,
	input logic        rx_last,
	input logic        res_valid,
	input logic        res_ready,
	input logic [1:0]  res_status,
	input logic [7:0]  res_id,
	input logic [15:0] res_crc
);

	// A final item always yields a result in the next cycle
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_valid && rx_ready && rx_last) |=> res_valid)
		else $error("final item gave no result");

	// An item that is not final never conjures a result from an empty output
	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!res_valid && !(rx_valid && rx_ready && rx_last)) |=> !res_valid)
		else $error("result appeared without a final item");

	// A stalled result keeps its valid
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> res_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_payload_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=>
		($stable(res_status) && $stable(res_id) && $stable(res_crc)))
		else $error("result payload changed while stalled");

endmodule

bind framed_message_crc_checker fmcc_checker u_fmcc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rx_valid   (rx_byte.valid),
	.rx_ready   (rx_byte.ready),
	.rx_last    (rx_byte.last_byte),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_status (result.status),
	.res_id     (result.message_id),
	.res_crc    (result.computed_crc)
);

[bench/tb_framed_message_crc_checker.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the framed message checker: directed and random frames.
module tb_framed_message_crc_checker;

	localparam int          WATCHDOG_CYCLES    = 400000;
	localparam int          DRAIN_CYCLES       = 8;
	localparam int          MAX_REPORTS        = 10;
	localparam int          PHASE_ITEMS        = 360;
	localparam logic [15:0] CRC_SEED           = 16'hFFFF;
	localparam logic [15:0] CRC_REFLECTED_POLY = 16'hA001;
	localparam logic [7:0]  START_AFTER_RESET  = 8'h7E;
	localparam logic [2:0]  COUNT_CEILING      = 3'd4;

	typedef logic [7:0] frame_bytes_t [$];
	typedef enum int {FR_GOOD, FR_BAD_START, FR_BAD_CRC, FR_SHORT, FR_NOISE} frame_kind_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       wr_en;
	logic [7:0] wr_data;

	fmcc_byte_if   rx_if ();
	fmcc_result_if res_if ();

	framed_message_crc_checker dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx_byte (rx_if),
		.result  (res_if),
		.wr_en   (wr_en),
		.wr_data (wr_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor copy of the register and the frame state
	logic [7:0]  start_reg;
	logic [15:0] crc_acc;
	logic [7:0]  older_byte;
	logic [7:0]  newer_byte;
	logic [2:0]  seen_count;
	logic        start_ok;
	logic [7:0]  frame_id;

	fmcc_pkg::result_t expected_results [$];
	int      fail_count = 0;
	int      items_accepted = 0;
	bit      gaps_on = 1'b0;
	int      burst_left = 0;
	int      hold_left = 0;
	int      cycle_count = 0;

	// Shift one byte through the reflected CRC-16, least significant bit first
	function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c  = c >> 1;
			if (fb) begin
				c = c ^ CRC_REFLECTED_POLY;
			end
		end
		return c;
	endfunction

	function automatic logic [15:0] crc16_of(frame_bytes_t q);
		logic [15:0] c;
		c = CRC_SEED;
		foreach (q[i]) begin
			c = crc16_update(c, q[i]);
		end
		return c;
	endfunction

	// Append the little-endian trailer
	function automatic frame_bytes_t with_crc(frame_bytes_t body);
		logic [15:0] c;
		c = crc16_of(body);
		body.push_back(c[7:0]);
		body.push_back(c[15:8]);
		return body;
	endfunction

	function void clear_frame_state();
		crc_acc    = CRC_SEED;
		older_byte = 8'h00;
		newer_byte = 8'h00;
		seen_count = 3'd0;
		start_ok   = 1'b0;
		frame_id   = 8'h00;
	endfunction

	// Advance the frame state by one accepted item; queue a result on the last byte
	function void frame_check_predict(logic [7:0] b, logic last);
		logic [15:0]       trailer;
		logic [2:0]        prior;
		fmcc_pkg::result_t r;
		prior = seen_count;
		if (prior == 3'd0) begin
			start_ok = (b == start_reg);
		end else if (prior == 3'd1) begin
			frame_id = b;
		end
		if (prior >= 3'd2) begin
			crc_acc = crc16_update(crc_acc, older_byte);
		end
		trailer    = {b, newer_byte};
		older_byte = newer_byte;
		newer_byte = b;
		if (seen_count < COUNT_CEILING) begin
			seen_count = seen_count + 3'd1;
		end
		if (last) begin
			r.message_id = (prior >= 3'd1) ? frame_id : 8'h00;
			if (prior < 3'd3) begin
				r.status = fmcc_pkg::ST_TOO_SHORT;
			end else if (!start_ok) begin
				r.status = fmcc_pkg::ST_BAD_START;
			end else if (trailer != crc_acc) begin
				r.status = fmcc_pkg::ST_BAD_CRC;
			end else begin
				r.status = fmcc_pkg::ST_OK;
			end
			r.computed_crc = crc_acc;
			expected_results.push_back(r);
			clear_frame_state();
		end
	endfunction

	function automatic frame_kind_t pick_kind();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return FR_GOOD;
		end else if (roll < 72) begin
			return FR_BAD_START;
		end else if (roll < 85) begin
			return FR_BAD_CRC;
		end else if (roll < 93) begin
			return FR_SHORT;
		end
		return FR_NOISE;
	endfunction

	// Mostly short payloads, now and then a long one
	function automatic frame_bytes_t build_frame(frame_kind_t kind);
		frame_bytes_t f;
		int           plen;
		int           pos;
		int           n;
		case (kind)
			FR_SHORT: begin
				n = $urandom_range(1, 3);
				f.push_back($urandom_range(0, 1) ? start_reg : 8'($urandom));
				repeat (n - 1) f.push_back(8'($urandom));
			end
			FR_NOISE: begin
				n = $urandom_range(1, 12);
				repeat (n) f.push_back(8'($urandom));
			end
			default: begin
				plen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
				f.push_back((kind == FR_BAD_START) ?
					start_reg ^ 8'($urandom_range(1, 255)) : start_reg);
				repeat (plen + 1) f.push_back(8'($urandom));
				f = with_crc(f);
				if (kind == FR_BAD_CRC) begin
					pos = $urandom_range(1, f.size() - 1);
					f[pos] = f[pos] ^ 8'(1 << $urandom_range(0, 7));
				end
			end
		endcase
		return f;
	endfunction

	task automatic report_failure(string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS) begin
			$display("mismatch: %s", msg);
		end
	endtask

	// Offer one item and hold it until taken; valid stays high for the caller
	task automatic send_item(logic [7:0] b, logic last);
		rx_if.valid     <= 1'b1;
		rx_if.data_byte <= b;
		rx_if.last_byte <= last;
		do @(posedge clk); while (!rx_if.ready);
		frame_check_predict(b, last);
		items_accepted++;
	endtask

	// Send in bursts with idle gaps between them
	task automatic offer_byte(logic [7:0] b, logic last);
		int gap;
		if (gaps_on && burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				rx_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0) begin
			burst_left--;
		end
		send_item(b, last);
	endtask

	task automatic send_frame(frame_bytes_t f);
		foreach (f[i]) begin
			offer_byte(f[i], i == f.size() - 1);
		end
	endtask

	// Drop valid, wait for every queued result, then let the pipeline settle
	task automatic wait_idle();
		rx_if.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_start_byte(logic [7:0] v);
		wait_idle();
		wr_en   <= 1'b1;
		wr_data <= v;
		@(posedge clk);
		wr_en     <= 1'b0;
		start_reg = v;
	endtask

	task automatic run_random_frames(int n_items);
		int stop_at;
		stop_at = items_accepted + n_items;
		while (items_accepted < stop_at) begin
			send_frame(build_frame(pick_kind()));
		end
	endtask

	// Frames of one to three bytes, with and without a valid start byte
	task automatic test_short_frames();
		send_frame('{8'h7E});
		send_frame('{8'h00});
		send_frame('{8'hFF, 8'hAB});
		send_frame('{8'h7E, 8'h01, 8'h55});
	endtask

	// One frame each for OK, bad start and bad CRC, plus a long one that saturates the byte count
	task automatic test_status_codes();
		frame_bytes_t f;
		send_frame(with_crc('{8'h7E, 8'hFF}));
		send_frame(with_crc('{8'h00, 8'h00}));
		f = with_crc('{8'h7E, 8'h10});
		f[3] = f[3] ^ 8'h80;
		send_frame(f);
		send_frame(with_crc('{8'h7E, 8'h42, 8'hFF, 8'h00, 8'h5A}));
	endtask

	// Hold the result side off for a long stretch while frames keep coming
	task automatic test_backpressure();
		gaps_on   = 1'b0;
		hold_left = 400;
		repeat (12) send_frame(build_frame(pick_kind()));
		gaps_on = 1'b1;
	endtask

	// Random traffic under several start byte settings, extremes included
	task automatic test_start_register();
		write_start_byte(8'h00);
		run_random_frames(PHASE_ITEMS);
		write_start_byte(8'hFF);
		run_random_frames(PHASE_ITEMS);
		write_start_byte(8'($urandom));
		run_random_frames(PHASE_ITEMS);
		write_start_byte(8'($urandom));
		run_random_frames(PHASE_ITEMS);
		write_start_byte(START_AFTER_RESET);
		run_random_frames(PHASE_ITEMS);
	endtask

	// Result side ready: a rotating pattern, renewed every so often, or a long hold-off
	logic [15:0] ready_pattern = 16'hFFFF;
	int          pattern_age = 0;

	always @(posedge clk) begin
		if (hold_left > 0) begin
			res_if.ready <= 1'b0;
			hold_left--;
		end else begin
			res_if.ready  <= ready_pattern[0];
			ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
		end
		pattern_age++;
		if (pattern_age == 128) begin
			pattern_age = 0;
			case ($urandom_range(0, 3))
				0: ready_pattern = 16'hFFFF;
				1: ready_pattern = 16'($urandom) | 16'h0001;
				2: ready_pattern = ~(16'h0001 << $urandom_range(1, 15));
				default: ready_pattern = (16'($urandom) & 16'($urandom)) | 16'h0001;
			endcase
		end
	end

	// Compare each delivered result with the oldest expectation
	always @(posedge clk) begin
		fmcc_pkg::result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (expected_results.size() == 0) begin
				report_failure($sformatf("unexpected result status %0d id %02h crc %04h",
					res_if.status, res_if.message_id, res_if.computed_crc));
			end else begin
				want = expected_results.pop_front();
				if (res_if.status !== want.status || res_if.message_id !== want.message_id ||
						res_if.computed_crc !== want.computed_crc) begin
					report_failure($sformatf(
						"expected status %0d id %02h crc %04h, got status %0d id %02h crc %04h",
						want.status, want.message_id, want.computed_crc,
						res_if.status, res_if.message_id, res_if.computed_crc));
				end
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < WATCHDOG_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("framed_message_crc_checker regression: fail");
		$finish;
	end

	initial begin
		arst_n          = 1'b0;
		rx_if.valid     = 1'b0;
		rx_if.data_byte = 8'h00;
		rx_if.last_byte = 1'b0;
		res_if.ready    = 1'b0;
		wr_en           = 1'b0;
		wr_data         = 8'h00;
		start_reg       = START_AFTER_RESET;
		clear_frame_state();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_short_frames();
		test_status_codes();
		gaps_on = 1'b1;
		test_backpressure();
		test_start_register();
		wait_idle();

		if (fail_count == 0) begin
			$display("framed_message_crc_checker regression: pass");
		end else begin
			$display("framed_message_crc_checker regression: fail");
		end
		$finish;
	end

endmodule
